// ===== sv/shfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Sync header frame parser package
// Shared constants and the result word type of the frame parser.
// ----------------------------------------------------------------------------
package shfp_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'h55;

	typedef struct packed {
		logic       hit;
		logic [7:0] kind;
		logic [7:0] ident;
		logic [7:0] length;
		logic [7:0] index;
		logic [7:0] data;
		logic       empty;
		logic       last;
	} shfp_result_t;

endpackage

// ===== sv/shfp_parse.sv =====
// ----------------------------------------------------------------------------
// Frame parser state machine
// Holds the parse phase and header fields and forms the result word for the
// byte presented on its input.
// ----------------------------------------------------------------------------
module shfp_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            rx_byte,
	output shfp_pkg::shfp_result_t result
);

	localparam logic [2:0] PH_WAIT_A  = 3'd0;
	localparam logic [2:0] PH_WAIT_B  = 3'd1;
	localparam logic [2:0] PH_KIND    = 3'd2;
	localparam logic [2:0] PH_IDENT   = 3'd3;
	localparam logic [2:0] PH_LENGTH  = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;

	logic [2:0] phase_q, phase_d;
	logic [7:0] kind_q, ident_q, length_q, count_q;
	logic [7:0] count_next;
	logic       pay_last;

	assign count_next = count_q + 8'd1;
	assign pay_last   = (count_next >= length_q) || (count_next == 8'd0);

	always_comb begin
		phase_d = phase_q;
		result  = '0;
		result.kind   = kind_q;
		result.ident  = ident_q;
		result.length = length_q;
		unique case (phase_q)
			PH_WAIT_A: begin
				phase_d = (rx_byte == shfp_pkg::SYNC_FIRST) ? PH_WAIT_B : PH_WAIT_A;
			end
			PH_WAIT_B: begin
				if (rx_byte == shfp_pkg::SYNC_SECOND) begin
					phase_d = PH_KIND;
				end else if (rx_byte == shfp_pkg::SYNC_FIRST) begin
					phase_d = PH_WAIT_B;
				end else begin
					phase_d = PH_WAIT_A;
				end
			end
			PH_KIND: begin
				phase_d = PH_IDENT;
			end
			PH_IDENT: begin
				phase_d = PH_LENGTH;
			end
			PH_LENGTH: begin
				result.length = rx_byte;
				if (rx_byte == 8'd0) begin
					result.hit   = 1'b1;
					result.empty = 1'b1;
					result.last  = 1'b1;
					phase_d      = PH_WAIT_A;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				result.hit   = 1'b1;
				result.index = count_q;
				result.data  = rx_byte;
				result.last  = pay_last;
				phase_d      = pay_last ? PH_WAIT_A : PH_PAYLOAD;
			end
			default: begin
				phase_d = PH_WAIT_A;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT_A;
			kind_q   <= '0;
			ident_q  <= '0;
			length_q <= '0;
			count_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			if (phase_q == PH_KIND) begin
				kind_q <= rx_byte;
			end
			if (phase_q == PH_IDENT) begin
				ident_q <= rx_byte;
			end
			if (phase_q == PH_LENGTH) begin
				length_q <= rx_byte;
				count_q  <= '0;
			end
			if (phase_q == PH_PAYLOAD) begin
				count_q <= count_next;
			end
		end
	end

endmodule

// ===== sv/sync_header_frame_parser_top.sv =====
// An accepted word is registered in the input register, and its result word is registered in the output register.
// Throughput: one input word per cycle while the output is not stalled; while a
// stalled result waits in the output register, the input register loads only if it is empty.
// The input register and the output register are one stage each; the parse
// phase advances with the output register. Stalls on the output back up through both registers.
// Reset clears the parse phase, the header fields and both valid flags.
// ----------------------------------------------------------------------------
// Sync header frame parser top level
// Finds the 0xAA 0x55 sync pair, reads kind, id and length and streams out
// the payload bytes of each frame, or a single empty word for a frame of length zero.
// ----------------------------------------------------------------------------
module sync_header_frame_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] frame_kind,
	output logic [7:0] frame_ident,
	output logic [7:0] frame_length,
	output logic [7:0] byte_index,
	output logic [7:0] payload_byte,
	output logic       empty_frame,
	output logic       last_of_frame
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  advance;
	logic                  load_s1;
	shfp_pkg::shfp_result_t res;
	shfp_pkg::shfp_result_t res_q;
	logic                  out_valid_q;

	assign advance  = !(out_valid_q && out_stall);
	assign load_s1  = !valid_s1 || advance;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	shfp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.rx_byte (byte_s1),
		.result  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res.hit) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_kind    = res_q.kind;
	assign frame_ident   = res_q.ident;
	assign frame_length  = res_q.length;
	assign byte_index    = res_q.index;
	assign payload_byte  = res_q.data;
	assign empty_frame   = res_q.empty;
	assign last_of_frame = res_q.last;

endmodule

// ===== sv/shfp_checker.sv =====
// ----------------------------------------------------------------------------
// Sync header frame parser checker
// Port-level checks on the result words of the frame parser.
// ----------------------------------------------------------------------------
module shfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] frame_length,
	input logic [7:0] byte_index,
	input logic [7:0] payload_byte,
	input logic       empty_frame,
	input logic       last_of_frame
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(byte_index) && $stable(payload_byte))
		else $error("Stalled result word changed.");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_frame |-> last_of_frame && frame_length == 8'd0
			&& byte_index == 8'd0 && payload_byte == 8'd0)
		else $error("Empty frame word is malformed.");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !empty_frame |-> byte_index < frame_length)
		else $error("Payload index is outside the declared length.");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !empty_frame |->
			last_of_frame == (byte_index == frame_length - 8'd1))
		else $error("Last flag does not match the final payload index.");

endmodule

bind sync_header_frame_parser_top shfp_checker u_shfp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.frame_length  (frame_length),
	.byte_index    (byte_index),
	.payload_byte  (payload_byte),
	.empty_frame   (empty_frame),
	.last_of_frame (last_of_frame)
);
